// ===== rtl/argb_pixel_blend_unit_macros.svh =====
// assertion macros for the argb pixel blend unit
// needs clk and arst_n in the module that uses them
`ifndef ARGB_PIXEL_BLEND_UNIT_MACROS_SVH
`define ARGB_PIXEL_BLEND_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BLEND_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BLEND_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BLEND_ASSERT_IMPLY(lbl, ante, cons, msg)
`define BLEND_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/abu_pkg.sv =====
// shared types, constants and arithmetic helpers of the argb pixel blend unit
// no dependencies
package abu_pkg;

	localparam int unsigned NUM_STAGES = 7;
	localparam logic [7:0] CH_MAX = 8'hff;

	typedef enum logic [1:0] {
		OP_MIX    = 2'd0,
		OP_OVER   = 2'd1,
		OP_BRIGHT = 2'd2,
		OP_PASS   = 2'd3
	} op_t;

	typedef struct packed {
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} div_adv_t;

	typedef struct packed {
		logic        bit_q;
		logic [15:0] rem;
	} div_step_t;

	// exact floor(x / 255) for x up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [15:0] t;
		t = x + {8'd0, x[15:8]} + 16'd1;
		return t[15:8];
	endfunction

	function automatic div_step_t div_step(input logic [15:0] rem, input logic [7:0] den,
		input int unsigned sh);
		logic [15:0] d;
		div_step_t   r;
		d = {8'd0, den} << sh;
		if (rem >= d) begin
			r.bit_q = 1'b1;
			r.rem   = rem - d;
		end else begin
			r.bit_q = 1'b0;
			r.rem   = rem;
		end
		return r;
	endfunction

endpackage

// ===== rtl/abu_chan_div.sv =====
// four-stage restoring divider for one colour channel, two quotient bits per stage
// depends on abu_pkg
module abu_chan_div import abu_pkg::*; (
	input  logic        clk,
	input  div_adv_t    adv,
	input  logic [15:0] num,
	input  logic [7:0]  den,
	output logic [7:0]  quot
);

	logic [15:0] rem_s4, rem_s5, rem_s6;
	logic [7:0]  den_s4, den_s5, den_s6;
	logic [1:0]  q_s4;
	logic [3:0]  q_s5;
	logic [5:0]  q_s6;
	logic [7:0]  q_s7;

	div_step_t st7, st6, st5, st4, st3, st2, st1, st0;

	always_comb begin
		st7 = div_step(num, den, 7);
		st6 = div_step(st7.rem, den, 6);
		st5 = div_step(rem_s4, den_s4, 5);
		st4 = div_step(st5.rem, den_s4, 4);
		st3 = div_step(rem_s5, den_s5, 3);
		st2 = div_step(st3.rem, den_s5, 2);
		st1 = div_step(rem_s6, den_s6, 1);
		st0 = div_step(st1.rem, den_s6, 0);
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			rem_s4 <= st6.rem;
			den_s4 <= den;
			q_s4   <= {st7.bit_q, st6.bit_q};
		end
		if (adv.s5) begin
			rem_s5 <= st4.rem;
			den_s5 <= den_s4;
			q_s5   <= {q_s4, st5.bit_q, st4.bit_q};
		end
		if (adv.s6) begin
			rem_s6 <= st2.rem;
			den_s6 <= den_s5;
			q_s6   <= {q_s5, st3.bit_q, st2.bit_q};
		end
		if (adv.s7) begin
			q_s7 <= {q_s6, st1.bit_q, st0.bit_q};
		end
	end

	assign quot = q_s7;

endmodule

// ===== rtl/argb_pixel_blend_unit.sv =====
// argb pixel blend unit: mix, over composite, brightness or pass-through on one pixel pair
// one transaction per cycle unless a stalled output has filled the pipeline
// a 7-stage pipeline: products, divide by 255, over numerators, 4 divider stages
// a stalled output backs up stage by stage; bubbles are squeezed out
// asynchronous reset clears the stage valid bits only; depends on abu_pkg, abu_chan_div
`include "argb_pixel_blend_unit_macros.svh"
module argb_pixel_blend_unit import abu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [31:0]        pixel_a,
	input  logic [31:0]        pixel_b,
	input  logic [7:0]         mix_weight,
	input  logic signed [9:0]  gain,
	input  logic signed [9:0]  offset,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        result_pixel
);

	logic [NUM_STAGES:1] vld_q;
	logic [NUM_STAGES:1] adv;

	// stage 1 inputs
	logic               byp_d;
	logic [31:0]        bpix_d;
	logic [3:0]         up_d;
	logic [7:0]         diff_d [4];
	logic [15:0]        mprod_d [4];
	logic signed [17:0] bprod_d [3];
	logic [15:0]        oprod_d;

	// stage 1 registers
	op_t                op_s1;
	logic               byp_s1;
	logic [31:0]        bpix_s1;
	logic [31:0]        pixel_a_s1;
	logic [31:0]        pixel_b_s1;
	logic [3:0]         up_s1;
	logic [15:0]        mprod_s1 [4];
	logic signed [17:0] bprod_s1 [3];
	logic [15:0]        oprod_s1;
	logic signed [9:0]  offset_s1;

	// stage 2
	logic [7:0]         mq [4];
	logic [31:0]        mix_pix;
	logic signed [17:0] bsh [3];
	logic signed [10:0] bv [3];
	logic [31:0]        bright_pix;
	logic [31:0]        res_d2;
	logic [7:0]         aa_d2;
	logic [31:0]        res_s2;
	logic               div_s2;
	logic [7:0]         aa_s2;
	logic [7:0]         sum_s2;
	logic [23:0]        pa_s2;
	logic [31:0]        pb_s2;

	// stage 3 and divider stages
	logic [15:0] num_d3 [3];
	logic [15:0] num_s3 [3];
	logic [7:0]  sum_s3;
	logic [31:0] res_s3, res_s4, res_s5, res_s6, res_s7;
	logic        div_s3, div_s4, div_s5, div_s6, div_s7;
	logic [7:0]  alpha_s4, alpha_s5, alpha_s6, alpha_s7;
	logic [7:0]  quot [3];
	div_adv_t    div_adv;

	logic in_fire, out_fire;

	always_comb begin
		adv[NUM_STAGES] = !vld_q[NUM_STAGES] || out_ready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k + 1];
		end
	end

	assign in_ready  = adv[1];
	assign out_valid = vld_q[NUM_STAGES];
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k - 1];
				end
			end
		end
	end

	// stage 1: special cases and products
	always_comb begin
		byp_d  = 1'b0;
		bpix_d = pixel_a;
		case (op_t'(opcode))
			OP_MIX: begin
				byp_d  = mix_weight inside {8'd0, CH_MAX};
				bpix_d = (mix_weight == 8'd0) ? pixel_a : pixel_b;
			end
			OP_OVER: begin
				byp_d  = (pixel_b[31:24] inside {CH_MAX, 8'd0}) ||
					(pixel_a[31:24] == 8'd0);
				bpix_d = (pixel_b[31:24] == 8'd0) ? pixel_a : pixel_b;
			end
			OP_BRIGHT: begin
				byp_d  = (gain == 10'sd255) && (offset == 10'sd0);
				bpix_d = {8'd0, pixel_a[23:0]};
			end
			default: begin
				byp_d  = 1'b1;
				bpix_d = pixel_a;
			end
		endcase
		for (int c = 0; c < 4; c++) begin
			up_d[c]    = pixel_b[8*c +: 8] >= pixel_a[8*c +: 8];
			diff_d[c]  = up_d[c] ? pixel_b[8*c +: 8] - pixel_a[8*c +: 8]
				: pixel_a[8*c +: 8] - pixel_b[8*c +: 8];
			mprod_d[c] = {8'd0, diff_d[c]} * {8'd0, mix_weight};
		end
		for (int c = 0; c < 3; c++) begin
			bprod_d[c] = $signed({10'd0, pixel_a[8*c +: 8]}) * $signed({{8{gain[9]}}, gain});
		end
		oprod_d = {8'd0, CH_MAX - pixel_b[31:24]} * {8'd0, pixel_a[31:24]};
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			op_s1      <= op_t'(opcode);
			byp_s1     <= byp_d;
			bpix_s1    <= bpix_d;
			pixel_a_s1 <= pixel_a;
			pixel_b_s1 <= pixel_b;
			up_s1      <= up_d;
			mprod_s1   <= mprod_d;
			bprod_s1   <= bprod_d;
			oprod_s1   <= oprod_d;
			offset_s1  <= offset;
		end
	end

	// stage 2: divide by 255, brightness clamp
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			mq[c] = div255(mprod_s1[c]);
			mix_pix[8*c +: 8] = up_s1[c] ? pixel_a_s1[8*c +: 8] + mq[c]
				: pixel_a_s1[8*c +: 8] - mq[c];
		end
		bright_pix[31:24] = 8'd0;
		for (int c = 0; c < 3; c++) begin
			bsh[c] = bprod_s1[c] >>> 8;
			bv[c]  = $signed(bsh[c][10:0]) + $signed({offset_s1[9], offset_s1});
			if (bv[c] < 11'sd0) begin
				bright_pix[8*c +: 8] = 8'd0;
			end else if (bv[c] > 11'sd255) begin
				bright_pix[8*c +: 8] = CH_MAX;
			end else begin
				bright_pix[8*c +: 8] = bv[c][7:0];
			end
		end
		if (byp_s1) begin
			res_d2 = bpix_s1;
		end else if (op_s1 == OP_MIX) begin
			res_d2 = mix_pix;
		end else begin
			res_d2 = bright_pix;
		end
		aa_d2 = div255(oprod_s1);
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			res_s2 <= res_d2;
			div_s2 <= (op_s1 == OP_OVER) && !byp_s1;
			aa_s2  <= aa_d2;
			sum_s2 <= aa_d2 + pixel_b_s1[31:24];
			pa_s2  <= pixel_a_s1[23:0];
			pb_s2  <= pixel_b_s1;
		end
	end

	// stage 3: over numerators
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			num_d3[c] = {8'd0, pa_s2[8*c +: 8]} * {8'd0, aa_s2}
				+ {8'd0, pb_s2[8*c +: 8]} * {8'd0, pb_s2[31:24]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			num_s3 <= num_d3;
			sum_s3 <= sum_s2;
			res_s3 <= res_s2;
			div_s3 <= div_s2;
		end
		if (adv[4]) begin
			res_s4   <= res_s3;
			div_s4   <= div_s3;
			alpha_s4 <= sum_s3;
		end
		if (adv[5]) begin
			res_s5   <= res_s4;
			div_s5   <= div_s4;
			alpha_s5 <= alpha_s4;
		end
		if (adv[6]) begin
			res_s6   <= res_s5;
			div_s6   <= div_s5;
			alpha_s6 <= alpha_s5;
		end
		if (adv[7]) begin
			res_s7   <= res_s6;
			div_s7   <= div_s6;
			alpha_s7 <= alpha_s6;
		end
	end

	assign div_adv = '{s4: adv[4], s5: adv[5], s6: adv[6], s7: adv[7]};

	for (genvar c = 0; c < 3; c++) begin : g_div
		abu_chan_div u_div (
			.clk  (clk),
			.adv  (div_adv),
			.num  (num_s3[c]),
			.den  (sum_s3),
			.quot (quot[c])
		);
	end

	assign result_pixel = div_s7 ? {alpha_s7, quot[2], quot[1], quot[0]} : res_s7;

	`BLEND_ASSERT_NEXT(a_fill, in_fire && !out_fire,
		$countones(vld_q) == $past($countones(vld_q)) + 1, "pipeline lost an accepted transaction")
	`BLEND_ASSERT_NEXT(a_drain, out_fire && !in_fire,
		$countones(vld_q) == $past($countones(vld_q)) - 1, "pipeline repeated a transaction")
	`BLEND_ASSERT_IMPLY(a_full_stall, (&vld_q) && !out_ready, !in_ready,
		"full stalled pipeline took a transaction")
	`BLEND_ASSERT_IMPLY(a_over_alpha, out_valid && div_s7, result_pixel[31:24] != 8'd0,
		"composite result with zero alpha")

endmodule
